@@ hdl/arpct_pkg.sv @@
`default_nettype none

package arpct_pkg;

    // Table geometry and register reset
    localparam int          ENTRIES_DEF     = 32;
    localparam int          AGE_W           = 25;
    localparam int          LIMIT_W         = 24;
    localparam int          ELAPSED_W       = 16;
    localparam int          IP_W            = 32;
    localparam int          MAC_W           = 48;
    localparam logic [LIMIT_W-1:0] AGE_LIMIT_RESET = LIMIT_W'(20 * 60 * 60);

    // Item kinds
    typedef enum logic [1:0] {
        KIND_INSERT = 2'd0,
        KIND_LOOKUP = 2'd1,
        KIND_REMOVE = 2'd2,
        KIND_TICK   = 2'd3
    } kind_t;

    // Result codes
    typedef enum logic [1:0] {
        ST_DONE = 2'd0,
        ST_HIT  = 2'd1,
        ST_MISS = 2'd2,
        ST_FULL = 2'd3
    } status_t;

    // One table row as held in the RAM; validity lives in flops
    typedef struct packed {
        logic             stat;
        logic [IP_W-1:0]  ip;
        logic [MAC_W-1:0] mac;
        logic [AGE_W-1:0] age;
    } row_t;

    localparam int ROW_W = $bits(row_t);

    // Microcode
    localparam int PC_W = 3;

    typedef enum logic [2:0] {
        COND_NONE,
        COND_NO_ITEM,
        COND_SKIP,
        COND_SCAN_BUSY,
        COND_OUT_BLOCKED
    } cond_t;

    typedef struct packed {
        logic            take;
        logic            scan_init;
        logic            scan_step;
        logic            commit;
        logic            respond;
        logic            ret;
        cond_t           cond;
        logic [PC_W-1:0] target;
    } ctrl_t;

    // Condition inputs from the datapath
    typedef struct packed {
        logic no_item;
        logic skip;
        logic scan_busy;
        logic out_blocked;
    } flags_t;

    localparam logic [PC_W-1:0] PC_IDLE    = PC_W'(0);
    localparam logic [PC_W-1:0] PC_INIT    = PC_W'(1);
    localparam logic [PC_W-1:0] PC_SCAN    = PC_W'(2);
    localparam logic [PC_W-1:0] PC_COMMIT  = PC_W'(3);
    localparam logic [PC_W-1:0] PC_RESPOND = PC_W'(4);

    // Control store
    function automatic ctrl_t ucode_rom(input logic [PC_W-1:0] pc);
        ctrl_t w;
        w = '{take: 1'b0, scan_init: 1'b0, scan_step: 1'b0, commit: 1'b0,
              respond: 1'b0, ret: 1'b0, cond: COND_NONE, target: PC_IDLE};
        case (pc)
            PC_IDLE:
            begin
                w.take   = 1'b1;
                w.cond   = COND_NO_ITEM;
                w.target = PC_IDLE;
            end
            PC_INIT:
            begin
                w.scan_init = 1'b1;
                w.cond      = COND_SKIP;
                w.target    = PC_RESPOND;
            end
            PC_SCAN:
            begin
                w.scan_step = 1'b1;
                w.cond      = COND_SCAN_BUSY;
                w.target    = PC_SCAN;
            end
            PC_COMMIT:
            begin
                w.commit = 1'b1;
            end
            PC_RESPOND:
            begin
                w.respond = 1'b1;
                w.ret     = 1'b1;
                w.cond    = COND_OUT_BLOCKED;
                w.target  = PC_RESPOND;
            end
            default:
            begin
                w.ret = 1'b1;
            end
        endcase
        return w;
    endfunction

endpackage

`default_nettype wire

@@ hdl/arpct_if.sv @@
`default_nettype none

// Request channel: one table operation per item
interface arpct_req_if;
    import arpct_pkg::*;
    logic                 valid;
    logic                 ready;
    logic [1:0]           kind;
    logic [IP_W-1:0]      ip_address;
    logic [MAC_W-1:0]     mac_in;
    logic                 is_static;
    logic [ELAPSED_W-1:0] elapsed;

    modport source (output valid, kind, ip_address, mac_in, is_static, elapsed,
                    input ready);
    modport sink (input valid, kind, ip_address, mac_in, is_static, elapsed,
                  output ready);
endinterface

// Response channel: one result per request
interface arpct_rsp_if;
    import arpct_pkg::*;
    logic             valid;
    logic             ready;
    logic [1:0]       status;
    logic [MAC_W-1:0] mac_out;

    modport source (output valid, status, mac_out, input ready);
    modport sink (input valid, status, mac_out, output ready);
endinterface

`default_nettype wire

@@ hdl/arpct_ram.sv @@
`default_nettype none

module arpct_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 32
) (
    input  wire logic                     clk,
    input  wire logic                     wr_en,
    input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
    input  wire logic [WIDTH-1:0]         wr_data,
    input  wire logic                     rd_en,
    input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic      [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    // One write port, one registered read port
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

`default_nettype wire

@@ hdl/arpct_seq.sv @@
`default_nettype none

module arpct_seq
    import arpct_pkg::*;
(
    input  wire logic   clk,
    input  wire logic   rst_n,
    input  wire flags_t flags,
    output ctrl_t       ctrl
);

    logic [PC_W-1:0] pc_reg;
    logic [PC_W-1:0] pc_next;
    logic            jump;

    assign ctrl = ucode_rom(pc_reg);

    // Condition select
    always_comb
    begin
        case (ctrl.cond)
            COND_NONE:        jump = 1'b0;
            COND_NO_ITEM:     jump = flags.no_item;
            COND_SKIP:        jump = flags.skip;
            COND_SCAN_BUSY:   jump = flags.scan_busy;
            COND_OUT_BLOCKED: jump = flags.out_blocked;
            default:          jump = 1'b0;
        endcase
    end

    // Next step
    always_comb
    begin
        if (jump)
        begin
            pc_next = ctrl.target;
        end
        else if (ctrl.ret)
        begin
            pc_next = PC_IDLE;
        end
        else
        begin
            pc_next = pc_reg + PC_W'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pc_reg <= PC_IDLE;
        end
        else
        begin
            pc_reg <= pc_next;
        end
    end

endmodule

`default_nettype wire

@@ hdl/arp_cache_table_top.sv @@
`default_nettype none

// Channel  Dir  Handshake     Payload
// req      in   valid/ready   kind, ip_address, mac_in, is_static, elapsed
// rsp      out  valid/ready   status, mac_out
// cfg      in   cfg_wr_en     cfg_wr_data (age limit)
//
// The scan reads one RAM row per cycle, so the single table read port sets how
// long an item takes; an address-zero insert skips the scan.
// Reset clears the slot valid bits at once; no clearing pass is needed.
// The result sits in an output register, so the next item is taken while
// it waits; a stalled rsp only holds the sequencer in its final step.

module arp_cache_table_top
    import arpct_pkg::*;
#(
    parameter int ENTRIES = ENTRIES_DEF
) (
    input  wire logic               clk,
    input  wire logic               rst_n,
    arpct_req_if.sink               req,
    arpct_rsp_if.source             rsp,
    input  wire logic               cfg_wr_en,
    input  wire logic [LIMIT_W-1:0] cfg_wr_data
);

    localparam int IW = $clog2(ENTRIES);
    localparam int CW = $clog2(ENTRIES + 1);

    ctrl_t  ctrl;
    flags_t flags;

    // Item registers
    kind_t                kind_reg;
    logic [IP_W-1:0]      ip_reg;
    logic [MAC_W-1:0]     mac_reg;
    logic                 stat_reg;
    logic [ELAPSED_W-1:0] elapsed_reg;

    logic [LIMIT_W-1:0]   age_limit_reg;
    logic [ENTRIES-1:0]   valid_reg, valid_next;

    // Scan state
    logic [CW-1:0]        cnt_reg, cnt_next;
    logic                 rd_pend_reg, rd_pend_next;
    logic [IW-1:0]        eval_idx_reg, eval_idx_next;

    // Search trackers
    logic                 found_reg, found_next;
    logic [IW-1:0]        match_idx_reg, match_idx_next;
    logic [MAC_W-1:0]     match_mac_reg, match_mac_next;
    logic                 match_stat_reg, match_stat_next;
    logic                 free_found_reg, free_found_next;
    logic [IW-1:0]        free_idx_reg, free_idx_next;
    logic                 old_found_reg, old_found_next;
    logic [IW-1:0]        old_idx_reg, old_idx_next;
    logic [AGE_W-1:0]     old_age_reg, old_age_next;

    // Result and output registers
    status_t              res_status_reg, res_status_next;
    logic [MAC_W-1:0]     res_mac_reg, res_mac_next;
    logic                 out_valid_reg, out_valid_next;
    status_t              out_status_reg, out_status_next;
    logic [MAC_W-1:0]     out_mac_reg, out_mac_next;

    // RAM ports
    logic                 rd_en;
    logic [IW-1:0]        rd_addr;
    logic [ROW_W-1:0]     rd_data;
    logic                 wr_en;
    logic [IW-1:0]        wr_addr;
    row_t                 wr_row;
    row_t                 row;
    logic                 slot_ok;
    logic [AGE_W:0]       age_sum;
    logic                 accept;

    arpct_seq u_seq (
        .clk   (clk),
        .rst_n (rst_n),
        .flags (flags),
        .ctrl  (ctrl)
    );

    arpct_ram #(
        .WIDTH (ROW_W),
        .DEPTH (ENTRIES)
    ) u_ram (
        .clk     (clk),
        .wr_en   (wr_en),
        .wr_addr (wr_addr),
        .wr_data (wr_row),
        .rd_en   (rd_en),
        .rd_addr (rd_addr),
        .rd_data (rd_data)
    );

    assign req.ready = ctrl.take;
    assign accept    = req.valid & ctrl.take;

    assign row     = row_t'(rd_data);
    assign slot_ok = valid_reg[eval_idx_reg];
    assign age_sum = {1'b0, row.age} + (AGE_W + 1)'(elapsed_reg);

    // Sequencer conditions
    always_comb
    begin
        flags.no_item     = !req.valid;
        flags.skip        = (kind_reg == KIND_INSERT) && (ip_reg == '0);
        flags.scan_busy   = !(rd_pend_reg && (eval_idx_reg == IW'(ENTRIES - 1)));
        flags.out_blocked = out_valid_reg && !rsp.ready;
    end

    // Datapath driven by the current control word
    always_comb
    begin
        valid_next      = valid_reg;
        cnt_next        = cnt_reg;
        rd_pend_next    = rd_pend_reg;
        eval_idx_next   = eval_idx_reg;
        found_next      = found_reg;
        match_idx_next  = match_idx_reg;
        match_mac_next  = match_mac_reg;
        match_stat_next = match_stat_reg;
        free_found_next = free_found_reg;
        free_idx_next   = free_idx_reg;
        old_found_next  = old_found_reg;
        old_idx_next    = old_idx_reg;
        old_age_next    = old_age_reg;
        res_status_next = res_status_reg;
        res_mac_next    = res_mac_reg;
        rd_en           = 1'b0;
        rd_addr         = '0;
        wr_en           = 1'b0;
        wr_addr         = '0;
        wr_row          = row;

        // Start of scan: read slot 0, clear trackers and result
        if (ctrl.scan_init)
        begin
            rd_en           = 1'b1;
            rd_addr         = '0;
            cnt_next        = CW'(1);
            rd_pend_next    = 1'b1;
            eval_idx_next   = '0;
            found_next      = 1'b0;
            free_found_next = 1'b0;
            old_found_next  = 1'b0;
            res_status_next = ST_DONE;
            res_mac_next    = '0;
        end

        // Scan: issue the next read, evaluate the row that just arrived
        if (ctrl.scan_step)
        begin
            if (cnt_reg < CW'(ENTRIES))
            begin
                rd_en         = 1'b1;
                rd_addr       = cnt_reg[IW-1:0];
                cnt_next      = cnt_reg + CW'(1);
                rd_pend_next  = 1'b1;
                eval_idx_next = cnt_reg[IW-1:0];
            end
            else
            begin
                rd_pend_next = 1'b0;
            end

            if (rd_pend_reg)
            begin
                if (slot_ok && (row.ip == ip_reg) && !found_reg)
                begin
                    found_next      = 1'b1;
                    match_idx_next  = eval_idx_reg;
                    match_mac_next  = row.mac;
                    match_stat_next = row.stat;
                end
                if (!slot_ok && !free_found_reg)
                begin
                    free_found_next = 1'b1;
                    free_idx_next   = eval_idx_reg;
                end
                if (slot_ok && !row.stat && (!old_found_reg || (row.age > old_age_reg)))
                begin
                    old_found_next = 1'b1;
                    old_idx_next   = eval_idx_reg;
                    old_age_next   = row.age;
                end
                // Aging
                if ((kind_reg == KIND_TICK) && slot_ok && !row.stat)
                begin
                    if (row.age > AGE_W'(age_limit_reg))
                    begin
                        valid_next[eval_idx_reg] = 1'b0;
                    end
                    else
                    begin
                        wr_en      = 1'b1;
                        wr_addr    = eval_idx_reg;
                        wr_row.age = age_sum[AGE_W] ? '1 : age_sum[AGE_W-1:0];
                    end
                end
            end
        end

        // Commit the operation
        if (ctrl.commit)
        begin
            case (kind_reg)
                KIND_INSERT:
                begin
                    wr_row.stat = stat_reg;
                    wr_row.ip   = ip_reg;
                    wr_row.mac  = mac_reg;
                    wr_row.age  = '0;
                    if (found_reg)
                    begin
                        wr_en   = 1'b1;
                        wr_addr = match_idx_reg;
                    end
                    else if (free_found_reg)
                    begin
                        wr_en   = 1'b1;
                        wr_addr = free_idx_reg;
                    end
                    else if (old_found_reg)
                    begin
                        wr_en   = 1'b1;
                        wr_addr = old_idx_reg;
                    end
                    else
                    begin
                        res_status_next = ST_FULL;
                    end
                    if (wr_en)
                    begin
                        valid_next[wr_addr] = 1'b1;
                    end
                end
                KIND_LOOKUP:
                begin
                    if (found_reg && !match_stat_reg)
                    begin
                        res_status_next = ST_HIT;
                        res_mac_next    = match_mac_reg;
                    end
                    else
                    begin
                        res_status_next = ST_MISS;
                    end
                end
                KIND_REMOVE:
                begin
                    if (found_reg)
                    begin
                        valid_next[match_idx_reg] = 1'b0;
                    end
                end
                default:
                begin
                end
            endcase
        end
    end

    // Output register
    always_comb
    begin
        out_valid_next  = out_valid_reg;
        out_status_next = out_status_reg;
        out_mac_next    = out_mac_reg;
        if (rsp.ready)
        begin
            out_valid_next = 1'b0;
        end
        if (ctrl.respond && !flags.out_blocked)
        begin
            out_valid_next  = 1'b1;
            out_status_next = res_status_reg;
            out_mac_next    = res_mac_reg;
        end
    end

    assign rsp.valid   = out_valid_reg;
    assign rsp.status  = out_status_reg;
    assign rsp.mac_out = out_mac_reg;

    // Control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg     <= '0;
            age_limit_reg <= AGE_LIMIT_RESET;
            out_valid_reg <= 1'b0;
            rd_pend_reg   <= 1'b0;
            cnt_reg       <= '0;
        end
        else
        begin
            valid_reg     <= valid_next;
            out_valid_reg <= out_valid_next;
            rd_pend_reg   <= rd_pend_next;
            cnt_reg       <= cnt_next;
            if (cfg_wr_en)
            begin
                age_limit_reg <= cfg_wr_data;
            end
        end
    end

    // Payload registers
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            kind_reg    <= kind_t'(req.kind);
            ip_reg      <= req.ip_address;
            mac_reg     <= req.mac_in;
            stat_reg    <= req.is_static;
            elapsed_reg <= req.elapsed;
        end
        eval_idx_reg   <= eval_idx_next;
        found_reg      <= found_next;
        match_idx_reg  <= match_idx_next;
        match_mac_reg  <= match_mac_next;
        match_stat_reg <= match_stat_next;
        free_found_reg <= free_found_next;
        free_idx_reg   <= free_idx_next;
        old_found_reg  <= old_found_next;
        old_idx_reg    <= old_idx_next;
        old_age_reg    <= old_age_next;
        res_status_reg <= res_status_next;
        res_mac_reg    <= res_mac_next;
        out_status_reg <= out_status_next;
        out_mac_reg    <= out_mac_next;
    end

endmodule

`default_nettype wire

@@ test/tb.sv @@
`timescale 1ns / 100ps

module tb;
    import arpct_pkg::*;

    localparam int ENTRIES     = ENTRIES_DEF;
    localparam int POOL_SIZE   = 40;
    localparam int CYCLE_LIMIT = 600000;

    // Slot occupancy as the predictor tracks it
    typedef enum logic [1:0] {
        SLOT_FREE    = 2'd0,
        SLOT_STATIC  = 2'd1,
        SLOT_DYNAMIC = 2'd2
    } slot_use_t;

    typedef struct {
        status_t          status;
        logic [MAC_W-1:0] mac;
    } arp_reply_t;

    logic                 clk;
    logic                 rst_n;
    logic                 cfg_wr_en;
    logic [LIMIT_W-1:0]   cfg_wr_data;

    arpct_req_if req_ch ();
    arpct_rsp_if rsp_ch ();

    arp_cache_table_top #(
        .ENTRIES (ENTRIES)
    ) dut (
        .clk         (clk),
        .rst_n       (rst_n),
        .req         (req_ch),
        .rsp         (rsp_ch),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data)
    );

    // Predicted cache contents
    slot_use_t            slot_use [ENTRIES];
    logic [IP_W-1:0]      slot_ip  [ENTRIES];
    logic [MAC_W-1:0]     slot_mac [ENTRIES];
    logic [AGE_W-1:0]     slot_age [ENTRIES];
    logic [LIMIT_W-1:0]   cur_age_limit;

    arp_reply_t           replies_due [$];
    logic [IP_W-1:0]      addr_pool [POOL_SIZE];

    int mismatches;
    int cycle_count;
    int burst_left;
    int stall_left;
    int rx_mode;
    int rx_count;

    // 8 ns clock
    always
    begin
        clk = 1'b0;
        #4;
        clk = 1'b1;
        #4;
    end

    // Slot holding an address, or -1
    function automatic int slot_of(logic [IP_W-1:0] ip);
        int hit = -1;
        for (int i = 0; i < ENTRIES; i++)
            if (hit < 0 && slot_use[i] != SLOT_FREE && slot_ip[i] == ip)
                hit = i;
        return hit;
    endfunction

    // Apply one operation to the predicted cache and return its reply
    function automatic arp_reply_t cache_apply(kind_t op, logic [IP_W-1:0] ip,
                                               logic [MAC_W-1:0] mac, logic st,
                                               logic [ELAPSED_W-1:0] el);
        arp_reply_t r;
        int pick;
        int free_idx;
        int oldest;
        logic [AGE_W:0] sum;
        r.status = ST_DONE;
        r.mac    = '0;
        pick     = slot_of(ip);
        case (op)
            KIND_INSERT:
            begin
                if (ip != '0)
                begin
                    if (pick < 0)
                    begin
                        free_idx = -1;
                        oldest   = -1;
                        for (int i = 0; i < ENTRIES; i++)
                        begin
                            if (slot_use[i] == SLOT_FREE)
                            begin
                                if (free_idx < 0)
                                    free_idx = i;
                            end
                            else if (slot_use[i] == SLOT_DYNAMIC)
                            begin
                                // strictly greater: lowest index wins a tie
                                if (oldest < 0 || slot_age[i] > slot_age[oldest])
                                    oldest = i;
                            end
                        end
                        pick = (free_idx >= 0) ? free_idx : oldest;
                    end
                    if (pick < 0)
                        r.status = ST_FULL;
                    else
                    begin
                        slot_use[pick] = st ? SLOT_STATIC : SLOT_DYNAMIC;
                        slot_ip[pick]  = ip;
                        slot_mac[pick] = mac;
                        slot_age[pick] = '0;
                    end
                end
            end
            KIND_LOOKUP:
            begin
                if (pick >= 0 && slot_use[pick] == SLOT_DYNAMIC)
                begin
                    r.status = ST_HIT;
                    r.mac    = slot_mac[pick];
                end
                else
                    r.status = ST_MISS;
            end
            KIND_REMOVE:
            begin
                if (pick >= 0)
                    slot_use[pick] = SLOT_FREE;
            end
            default:
            begin
                // aging: expire first, otherwise add with saturation
                for (int i = 0; i < ENTRIES; i++)
                begin
                    if (slot_use[i] == SLOT_DYNAMIC)
                    begin
                        if (slot_age[i] > {1'b0, cur_age_limit})
                            slot_use[i] = SLOT_FREE;
                        else
                        begin
                            sum = {1'b0, slot_age[i]} + el;
                            slot_age[i] = sum[AGE_W] ? '1 : sum[AGE_W-1:0];
                        end
                    end
                end
            end
        endcase
        return r;
    endfunction

    function automatic logic [IP_W-1:0] fresh_address();
        logic [IP_W-1:0] a;
        do
            a = $urandom;
        while (a == '0);
        return a;
    endfunction

    function automatic logic [MAC_W-1:0] rand_mac();
        return MAC_W'({$urandom, $urandom});
    endfunction

    // Send one item; the sender works in bursts with random idle gaps
    task automatic issue_op(kind_t op, logic [IP_W-1:0] ip, logic [MAC_W-1:0] mac,
                            logic st, logic [ELAPSED_W-1:0] el);
        int gap;
        if (burst_left == 0)
        begin
            burst_left = $urandom_range(1, 24);
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 10);
            if (gap > 0)
            begin
                req_ch.valid <= 1'b0;
                repeat (gap) @(posedge clk);
            end
        end
        burst_left--;
        req_ch.valid      <= 1'b1;
        req_ch.kind       <= op;
        req_ch.ip_address <= ip;
        req_ch.mac_in     <= mac;
        req_ch.is_static  <= st;
        req_ch.elapsed    <= el;
        do
            @(posedge clk);
        while (req_ch.ready !== 1'b1);
        replies_due.push_back(cache_apply(op, ip, mac, st, el));
    endtask

    // Stop sending and wait for every outstanding reply
    task automatic wait_replies_drained();
        req_ch.valid <= 1'b0;
        burst_left = 0;
        do
            @(posedge clk);
        while (replies_due.size() != 0);
    endtask

    task automatic write_age_limit(logic [LIMIT_W-1:0] v);
        wait_replies_drained();
        cfg_wr_en   <= 1'b1;
        cfg_wr_data <= v;
        @(posedge clk);
        cur_age_limit = v;
        cfg_wr_en <= 1'b0;
    endtask

    task automatic check_reply(status_t st, logic [MAC_W-1:0] mac);
        arp_reply_t want;
        if (replies_due.size() == 0)
        begin
            mismatches++;
            if (mismatches <= 10)
                $display("reply with nothing pending: status=%0d mac=%h", st, mac);
        end
        else
        begin
            want = replies_due.pop_front();
            if (want.status !== st || want.mac !== mac)
            begin
                mismatches++;
                if (mismatches <= 10)
                    $display("reply differs: status exp %0d got %0d, mac exp %h got %h",
                             want.status, st, want.mac, mac);
            end
        end
    endtask

    // Reply sink: check, then stall on a pattern that changes mode
    always @(posedge clk)
    begin
        if (rst_n && rsp_ch.valid === 1'b1 && rsp_ch.ready === 1'b1)
            check_reply(status_t'(rsp_ch.status), rsp_ch.mac_out);
        rx_count++;
        if (rx_count % 400 == 0)
            rx_mode = (rx_mode + 1) % 3;
        if (stall_left > 0)
        begin
            stall_left--;
            rsp_ch.ready <= 1'b0;
        end
        else
        begin
            case (rx_mode)
                1: if ($urandom_range(0, 3) == 0) stall_left = $urandom_range(1, 3);
                2: if ($urandom_range(0, 15) == 0) stall_left = $urandom_range(5, 60);
                default: stall_left = 0;
            endcase
            rsp_ch.ready <= (stall_left == 0);
        end
    end

    // Field extremes, every kind, and the named corner cases
    task automatic test_directed();
        issue_op(KIND_INSERT, '0, rand_mac(), 1'b0, 16'($urandom));
        issue_op(KIND_LOOKUP, '0, rand_mac(), 1'b1, 16'($urandom));
        issue_op(KIND_INSERT, '1, '1, 1'b0, '1);
        issue_op(KIND_LOOKUP, '1, '0, 1'b0, '0);
        issue_op(KIND_INSERT, 32'd1, '0, 1'b1, '0);
        issue_op(KIND_LOOKUP, 32'd1, rand_mac(), 1'b0, '0);
        // same address again: replaces the static entry in place
        issue_op(KIND_INSERT, 32'd1, 48'h0000_0012_3456, 1'b0, '0);
        issue_op(KIND_LOOKUP, 32'd1, rand_mac(), 1'b0, '0);
        issue_op(KIND_LOOKUP, 32'd2, rand_mac(), 1'b0, '0);
        issue_op(KIND_REMOVE, 32'd2, rand_mac(), 1'b0, '0);
        issue_op(KIND_REMOVE, '1, rand_mac(), 1'b0, '0);
        issue_op(KIND_LOOKUP, '1, rand_mac(), 1'b0, '0);
        issue_op(KIND_REMOVE, '0, rand_mac(), 1'b1, '1);
        // aging at the reset limit: two full steps pass it, the tick after them frees
        issue_op(KIND_TICK, fresh_address(), rand_mac(), 1'b0, '0);
        issue_op(KIND_TICK, fresh_address(), rand_mac(), 1'b1, '1);
        issue_op(KIND_TICK, fresh_address(), rand_mac(), 1'b0, '1);
        issue_op(KIND_TICK, fresh_address(), rand_mac(), 1'b0, '0);
        issue_op(KIND_LOOKUP, 32'd1, rand_mac(), 1'b0, '0);
        issue_op(KIND_INSERT, 32'h8000_0000, 48'h8000_0000_0000, 1'b0, '0);
        issue_op(KIND_INSERT, 32'h7FFF_FFFF, 48'h7FFF_FFFF_FFFF, 1'b1, '0);
        issue_op(KIND_REMOVE, 32'h7FFF_FFFF, rand_mac(), 1'b0, '0);
        issue_op(KIND_LOOKUP, 32'h8000_0000, rand_mac(), 1'b0, '0);
    endtask

    // Fill every slot with static entries until the cache reports full
    task automatic test_static_fill();
        logic [IP_W-1:0] fill_ip [ENTRIES + 4];
        logic [IP_W-1:0] extra;
        for (int i = 0; i < ENTRIES + 4; i++)
        begin
            fill_ip[i] = fresh_address();
            issue_op(KIND_INSERT, fill_ip[i], rand_mac(), 1'b1, 16'($urandom));
        end
        extra = fresh_address();
        issue_op(KIND_INSERT, extra, rand_mac(), 1'b0, 16'($urandom));
        issue_op(KIND_INSERT, fill_ip[0], rand_mac(), 1'b1, 16'($urandom));
        issue_op(KIND_LOOKUP, fill_ip[0], rand_mac(), 1'b0, 16'($urandom));
        issue_op(KIND_TICK, fresh_address(), rand_mac(), 1'b0, '1);
        issue_op(KIND_REMOVE, fill_ip[5], rand_mac(), 1'b0, 16'($urandom));
        issue_op(KIND_INSERT, extra, rand_mac(), 1'b0, 16'($urandom));
        issue_op(KIND_LOOKUP, extra, rand_mac(), 1'b1, 16'($urandom));
        // one dynamic slot left, so this one evicts it
        issue_op(KIND_INSERT, fresh_address(), rand_mac(), 1'b1, 16'($urandom));
        issue_op(KIND_LOOKUP, extra, rand_mac(), 1'b0, 16'($urandom));
        for (int i = 0; i < ENTRIES + 4; i++)
            issue_op(KIND_REMOVE, fill_ip[i], rand_mac(), 1'b0, 16'($urandom));
    endtask

    // Dynamic entries with staggered ages, then evict by age
    task automatic test_aging_eviction();
        logic [IP_W-1:0] dyn_ip [ENTRIES + 8];
        write_age_limit('1);
        for (int i = 0; i < ENTRIES + 8; i++)
        begin
            dyn_ip[i] = fresh_address();
            if (i % 4 == 0)
                issue_op(KIND_TICK, fresh_address(), rand_mac(), 1'b0,
                         16'($urandom_range(0, 5000)));
            issue_op(KIND_INSERT, dyn_ip[i], rand_mac(), 1'b0, 16'($urandom));
            if (i >= ENTRIES)
                issue_op(KIND_LOOKUP, dyn_ip[$urandom_range(0, i)], rand_mac(), 1'b0,
                         16'($urandom));
        end
        for (int i = 0; i < ENTRIES + 8; i++)
            issue_op(KIND_REMOVE, dyn_ip[i], rand_mac(), 1'b0, 16'($urandom));
    endtask

    // Mixed traffic over a small address pool at one age limit
    task automatic test_random_traffic(logic [LIMIT_W-1:0] limit, int max_el,
                                       int count, bit pause_midway);
        int r;
        kind_t op;
        logic [IP_W-1:0] ip;
        write_age_limit(limit);
        for (int n = 0; n < count; n++)
        begin
            if (pause_midway && n == count / 2)
                wait_replies_drained();
            r  = $urandom_range(0, 99);
            ip = ($urandom_range(0, 3) == 0) ? IP_W'($urandom)
                                             : addr_pool[$urandom_range(0, POOL_SIZE - 1)];
            if (r < 35)
                op = KIND_INSERT;
            else if (r < 65)
                op = KIND_LOOKUP;
            else if (r < 75)
                op = KIND_REMOVE;
            else
                op = KIND_TICK;
            issue_op(op, ip, rand_mac(), ($urandom_range(0, 4) == 0),
                     16'($urandom_range(0, max_el)));
        end
    endtask

    // Watchdog
    initial
    begin
        cycle_count = 0;
        while (cycle_count < CYCLE_LIMIT)
        begin
            @(posedge clk);
            cycle_count++;
        end
        $display("arp_cache_table_top: mismatch");
        $finish;
    end

    initial
    begin
        rst_n             = 1'b0;
        cfg_wr_en         = 1'b0;
        cfg_wr_data       = '0;
        req_ch.valid      = 1'b0;
        req_ch.kind       = KIND_INSERT;
        req_ch.ip_address = '0;
        req_ch.mac_in     = '0;
        req_ch.is_static  = 1'b0;
        req_ch.elapsed    = '0;
        rsp_ch.ready      = 1'b0;
        mismatches        = 0;
        burst_left        = 0;
        stall_left        = 0;
        rx_mode           = 0;
        rx_count          = 0;
        cur_age_limit     = AGE_LIMIT_RESET;
        for (int i = 0; i < ENTRIES; i++)
        begin
            slot_use[i] = SLOT_FREE;
            slot_ip[i]  = '0;
            slot_mac[i] = '0;
            slot_age[i] = '0;
        end
        addr_pool[0] = '1;
        addr_pool[1] = 32'd1;
        for (int i = 2; i < POOL_SIZE; i++)
            addr_pool[i] = fresh_address();

        repeat (10) @(posedge clk);
        rst_n <= 1'b1;

        test_directed();
        test_static_fill();
        test_aging_eviction();
        test_random_traffic('0, 3, 200, 1'b0);
        test_random_traffic(24'd1000, 300, 250, 1'b1);
        test_random_traffic(AGE_LIMIT_RESET, 65535, 200, 1'b0);
        test_random_traffic('1, 65535, 200, 1'b0);
        test_random_traffic(24'd5000, 2000, 100, 1'b0);

        wait_replies_drained();
        repeat (ENTRIES + 10) @(posedge clk);
        if (mismatches == 0 && replies_due.size() == 0)
            $display("arp_cache_table_top: match");
        else
            $display("arp_cache_table_top: mismatch");
        $finish;
    end

endmodule

@@ arp_cache_table_top.f @@
hdl/arpct_pkg.sv
hdl/arpct_if.sv
hdl/arpct_ram.sv
hdl/arpct_seq.sv
hdl/arp_cache_table_top.sv
test/tb.sv
